// File: hdl/arc_pkg.sv
// Package for the address resolution cache.
// Holds field widths, the default table size, the request kinds and the sequencer states.
// Used by arc_ram.sv and address_resolution_cache_unit.sv.
package arc_pkg;

  localparam int ENTRIES_DEF = 16;
  localparam int IP_W        = 32;
  localparam int MAC_W       = 48;

  typedef struct packed {
    logic [MAC_W-1:0] mac;
    logic [IP_W-1:0]  ip;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  localparam logic MODE_LOOKUP = 1'b0;
  localparam logic MODE_INSERT = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

endpackage

// File: hdl/arc_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
// Depends on arc_pkg for the default entry width and depth.
module arc_ram
  import arc_pkg::*;
#(
  parameter int WIDTH = ENTRY_W,
  parameter int DEPTH = ENTRIES_DEF,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: hdl/address_resolution_cache_unit.sv
// Address resolution cache: maps IPv4 addresses to hardware addresses.
// Depends on arc_pkg and on arc_ram for the entry table.
// An insert passes through ST_DONE to the registered result; a lookup scans the stored
// entries newest first, reading one entry per cycle through the table's single read port,
// and ends early on a hit; a lookup on an empty table skips the scan. ST_DONE waits while
// the output is held, and a new request is taken only in ST_IDLE.
// Reset (rst, synchronous) empties the table by clearing the entry count; stored entries
// are not cleared and are never read before they are written.
module address_resolution_cache_unit
  import arc_pkg::*;
#(
  parameter int ENTRIES = ENTRIES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [IP_W+MAC_W-1:0] s_tdata,  // ip_address, mac_address
  input  logic               s_tuser,     // mode
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [MAC_W-1:0]   m_tdata,     // found_mac
  output logic [1:0]         m_tuser      // hit, full_drop
);

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W = $clog2(ENTRIES + 1);

  state_t             state, state_next;
  logic [CNT_W-1:0]   fill_count, fill_count_next;
  logic [IDX_W-1:0]   scan_idx, scan_idx_next;
  logic               issue_more, issue_more_next;
  logic               cmp_valid, cmp_valid_next;
  logic               cmp_last, cmp_last_next;
  logic [IP_W-1:0]    key_ip, key_ip_next;
  logic               res_hit, res_hit_next;
  logic               res_drop, res_drop_next;
  logic [MAC_W-1:0]   res_mac, res_mac_next;
  logic               m_tvalid_next;
  logic [MAC_W-1:0]   m_tdata_next;
  logic [1:0]         m_tuser_next;

  logic               accept;
  logic               out_free;
  logic               table_full;
  logic               match;
  logic [IP_W-1:0]    in_ip;
  logic [MAC_W-1:0]   in_mac;
  logic [CNT_W-1:0]   cnt_m1;
  entry_t             wr_entry;
  entry_t             rd_entry;
  logic [ENTRY_W-1:0] rd_raw;
  logic               ram_wr_en;
  logic               ram_rd_en;

  assign s_tready   = (state == ST_IDLE);
  assign accept     = s_tvalid && s_tready;
  assign out_free   = !m_tvalid || m_tready;
  assign in_ip      = s_tdata[IP_W-1:0];
  assign in_mac     = s_tdata[IP_W+MAC_W-1:IP_W];
  assign table_full = (fill_count == CNT_W'(ENTRIES));
  assign cnt_m1     = fill_count - CNT_W'(1);
  assign rd_entry   = entry_t'(rd_raw);
  assign match      = (rd_entry.ip == key_ip);

  always_comb begin
    wr_entry.ip  = in_ip;
    wr_entry.mac = in_mac;
  end

  arc_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(ENTRIES)
  ) u_table (
    .clk    (clk),
    .wr_en  (ram_wr_en),
    .wr_addr(fill_count[IDX_W-1:0]),
    .wr_data(wr_entry),
    .rd_en  (ram_rd_en),
    .rd_addr(scan_idx),
    .rd_data(rd_raw)
  );

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          if (s_tuser == MODE_LOOKUP && fill_count != '0) begin
            state_next = ST_SCAN;
          end else begin
            state_next = ST_DONE;
          end
        end
      end
      ST_SCAN: begin
        if (cmp_valid && (match || cmp_last)) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Datapath and outputs. The scan issues one read per cycle, newest entry first,
  // and compares the data of the read issued in the cycle before.
  always_comb begin
    fill_count_next = fill_count;
    scan_idx_next   = scan_idx;
    issue_more_next = issue_more;
    cmp_valid_next  = cmp_valid;
    cmp_last_next   = cmp_last;
    key_ip_next     = key_ip;
    res_hit_next    = res_hit;
    res_drop_next   = res_drop;
    res_mac_next    = res_mac;
    m_tvalid_next   = m_tvalid && !m_tready;
    m_tdata_next    = m_tdata;
    m_tuser_next    = m_tuser;
    ram_wr_en       = 1'b0;
    ram_rd_en       = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          key_ip_next     = in_ip;
          res_hit_next    = 1'b0;
          res_drop_next   = 1'b0;
          res_mac_next    = '0;
          scan_idx_next   = cnt_m1[IDX_W-1:0];
          issue_more_next = 1'b1;
          cmp_valid_next  = 1'b0;
          cmp_last_next   = 1'b0;
          if (s_tuser == MODE_INSERT) begin
            if (table_full) begin
              res_drop_next = 1'b1;
            end else begin
              ram_wr_en       = 1'b1;
              fill_count_next = fill_count + CNT_W'(1);
            end
          end
        end
      end
      ST_SCAN: begin
        if (cmp_valid && match) begin
          res_hit_next    = 1'b1;
          res_mac_next    = rd_entry.mac;
          issue_more_next = 1'b0;
          cmp_valid_next  = 1'b0;
        end else if (cmp_valid && cmp_last) begin
          issue_more_next = 1'b0;
          cmp_valid_next  = 1'b0;
        end else begin
          ram_rd_en      = issue_more;
          cmp_valid_next = issue_more;
          cmp_last_next  = (scan_idx == '0);
          if (issue_more) begin
            if (scan_idx == '0) begin
              issue_more_next = 1'b0;
            end else begin
              scan_idx_next = scan_idx - IDX_W'(1);
            end
          end
        end
      end
      ST_DONE: begin
        if (out_free) begin
          m_tvalid_next = 1'b1;
          m_tdata_next  = res_mac;
          m_tuser_next  = {res_drop, res_hit};
        end
      end
      default: begin
        issue_more_next = 1'b0;
        cmp_valid_next  = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      fill_count <= '0;
      issue_more <= 1'b0;
      cmp_valid  <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      state      <= state_next;
      fill_count <= fill_count_next;
      issue_more <= issue_more_next;
      cmp_valid  <= cmp_valid_next;
      m_tvalid   <= m_tvalid_next;
    end
  end

  always_ff @(posedge clk) begin
    scan_idx <= scan_idx_next;
    cmp_last <= cmp_last_next;
    key_ip   <= key_ip_next;
    res_hit  <= res_hit_next;
    res_drop <= res_drop_next;
    res_mac  <= res_mac_next;
    m_tdata  <= m_tdata_next;
    m_tuser  <= m_tuser_next;
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= CNT_W'(ENTRIES))
    else $error("entry count exceeds table size");

  a_fill_grows_on_insert: assert property (@(posedge clk) disable iff (rst)
    (accept && s_tuser == MODE_INSERT && !table_full)
      |=> fill_count == $past(fill_count) + CNT_W'(1))
    else $error("accepted insert did not add an entry");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
    else $error("result is both a hit and a dropped insert");

  a_miss_zero_mac: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser[0]) |-> m_tdata == '0)
    else $error("result without a hit carries a hardware address");

  a_compare_in_scan: assert property (@(posedge clk) disable iff (rst)
    cmp_valid |-> state == ST_SCAN)
    else $error("compare pending outside the scan");

endmodule
